// ----- rtl/tlv_ff_pkg.sv -----
// ----------------------------------------------------------------------------
// tlv_ff_pkg
// Shared types and constants of the TLV field filter.
// ----------------------------------------------------------------------------
package tlv_ff_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned COUNT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WANTED_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ANY = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    HDR_ID_HI   = 2'd0,
    HDR_ID_LO   = 2'd1,
    HDR_SIZE_HI = 2'd2,
    HDR_SIZE_LO = 2'd3
  } hdr_pos_e;

  typedef struct packed {
    logic [ID_W-1:0] wanted_id;
    logic            match_any;
  } cfg_t;

  typedef struct packed {
    logic                field_found;
    logic [ID_W-1:0]     field_id;
    logic [SIZE_W-1:0]   field_size;
    logic [OFFSET_W-1:0] payload_offset;
    logic                package_end;
    logic                incomplete;
    logic [COUNT_W-1:0]  fields_matched;
  } res_t;

endpackage

// ----- rtl/tlv_ff_if.sv -----
// ----------------------------------------------------------------------------
// tlv_ff_if
// Valid/ready channels of the TLV field filter: byte input, result output
// and register write.
// ----------------------------------------------------------------------------
interface tlv_ff_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tlv_ff_result_if;
  logic                             valid;
  logic                             ready;
  logic                             field_found;
  logic [tlv_ff_pkg::ID_W-1:0]      field_id;
  logic [tlv_ff_pkg::SIZE_W-1:0]    field_size;
  logic [tlv_ff_pkg::OFFSET_W-1:0]  payload_offset;
  logic                             package_end;
  logic                             incomplete;
  logic [tlv_ff_pkg::COUNT_W-1:0]   fields_matched;

  modport source (output valid, field_found, field_id, field_size, payload_offset,
                  package_end, incomplete, fields_matched, input ready);
  modport sink   (input valid, field_found, field_id, field_size, payload_offset,
                  package_end, incomplete, fields_matched, output ready);
endinterface

interface tlv_ff_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tlv_ff_pkg::CFG_IDX_W-1:0]  index;
  logic [tlv_ff_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tlv_ff_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tlv_ff_cfg_regs
// Register file of the filter: wanted id and match-any flag.
// ----------------------------------------------------------------------------
module tlv_ff_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [tlv_ff_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [tlv_ff_pkg::CFG_DATA_W-1:0] wr_data_i,
  output tlv_ff_pkg::cfg_t                  cfg_o
);

  logic [tlv_ff_pkg::ID_W-1:0] wanted_id_q;
  logic                        match_any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_id_q <= '0;
      match_any_q <= 1'b1;
    end else if (wr_en_i) begin
      case (wr_index_i)
        tlv_ff_pkg::REG_WANTED_ID: wanted_id_q <= wr_data_i[tlv_ff_pkg::ID_W-1:0];
        tlv_ff_pkg::REG_MATCH_ANY: match_any_q <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.wanted_id = wanted_id_q;
  assign cfg_o.match_any = match_any_q;

endmodule

// ----- rtl/tlv_ff_parser.sv -----
// ----------------------------------------------------------------------------
// tlv_ff_parser
// Record parser state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module tlv_ff_parser #(
  parameter int unsigned PACKAGE_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  tlv_ff_pkg::cfg_t  cfg_i,
  output logic              emit_o,
  output tlv_ff_pkg::res_t  res_o
);

  localparam int unsigned PW = $clog2(PACKAGE_BYTES + 1);
  localparam int unsigned SW = (PW > tlv_ff_pkg::OFFSET_W) ? PW : tlv_ff_pkg::OFFSET_W;
  localparam int unsigned IW = tlv_ff_pkg::ID_W;
  localparam int unsigned ZW = tlv_ff_pkg::SIZE_W;
  localparam int unsigned CW = tlv_ff_pkg::COUNT_W;

  logic                 in_payload_q, in_payload_d;
  tlv_ff_pkg::hdr_pos_e hdr_pos_q, hdr_pos_d;
  logic [IW-1:0]        record_id_q, record_id_d;
  logic [ZW-1:0]        record_size_q, record_size_d;
  logic [ZW-1:0]        bytes_left_q, bytes_left_d;
  logic [PW-1:0]        byte_pos_q, byte_pos_d;
  logic [tlv_ff_pkg::OFFSET_W-1:0] payload_start_q, payload_start_d;
  logic [CW-1:0]        matched_q, matched_d;
  logic                 overrun_q, overrun_d;

  logic          full;
  logic          done;
  logic          found;
  logic [SW-1:0] pos_inc;
  logic [ZW-1:0] left_dec;

  assign full     = (byte_pos_q >= PW'(PACKAGE_BYTES));
  assign pos_inc  = SW'(byte_pos_q) + SW'(1);
  assign left_dec = bytes_left_q - ZW'(1);

  always_comb begin
    in_payload_d    = in_payload_q;
    hdr_pos_d       = hdr_pos_q;
    record_id_d     = record_id_q;
    record_size_d   = record_size_q;
    bytes_left_d    = bytes_left_q;
    byte_pos_d      = byte_pos_q;
    payload_start_d = payload_start_q;
    overrun_d       = overrun_q;
    done            = 1'b0;
    if (full) begin
      overrun_d = 1'b1;
    end else begin
      byte_pos_d = byte_pos_q + PW'(1);
      if (!in_payload_q) begin
        case (hdr_pos_q)
          tlv_ff_pkg::HDR_ID_HI: begin
            record_id_d = {data_byte_i, 8'h00};
            hdr_pos_d   = tlv_ff_pkg::HDR_ID_LO;
          end
          tlv_ff_pkg::HDR_ID_LO: begin
            record_id_d = {record_id_q[IW-1:8], data_byte_i};
            hdr_pos_d   = tlv_ff_pkg::HDR_SIZE_HI;
          end
          tlv_ff_pkg::HDR_SIZE_HI: begin
            record_size_d = {data_byte_i, 8'h00};
            hdr_pos_d     = tlv_ff_pkg::HDR_SIZE_LO;
          end
          default: begin
            record_size_d   = {record_size_q[ZW-1:8], data_byte_i};
            hdr_pos_d       = tlv_ff_pkg::HDR_ID_HI;
            payload_start_d = pos_inc[tlv_ff_pkg::OFFSET_W-1:0];
            if (record_size_d == '0) begin
              done = 1'b1;
            end else begin
              in_payload_d = 1'b1;
              bytes_left_d = record_size_d;
            end
          end
        endcase
      end else begin
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          in_payload_d = 1'b0;
          done         = 1'b1;
        end
      end
    end
  end

  assign found = done && (cfg_i.match_any || (record_id_d == cfg_i.wanted_id));

  always_comb begin
    matched_d = matched_q;
    if (found && (matched_q != '1)) begin
      matched_d = matched_q + CW'(1);
    end
  end

  assign emit_o = found || last_byte_i;

  always_comb begin
    res_o.field_found    = found;
    res_o.field_id       = found ? record_id_d : '0;
    res_o.field_size     = found ? record_size_d : '0;
    res_o.payload_offset = found ? payload_start_d : '0;
    res_o.package_end    = last_byte_i;
    res_o.incomplete     = last_byte_i &&
                           (overrun_d || in_payload_d || (hdr_pos_d != tlv_ff_pkg::HDR_ID_HI));
    res_o.fields_matched = matched_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q    <= 1'b0;
      hdr_pos_q       <= tlv_ff_pkg::HDR_ID_HI;
      record_id_q     <= '0;
      record_size_q   <= '0;
      bytes_left_q    <= '0;
      byte_pos_q      <= '0;
      payload_start_q <= '0;
      matched_q       <= '0;
      overrun_q       <= 1'b0;
    end else if (step_i) begin
      record_id_q     <= record_id_d;
      record_size_q   <= record_size_d;
      bytes_left_q    <= bytes_left_d;
      payload_start_q <= payload_start_d;
      if (last_byte_i) begin
        in_payload_q <= 1'b0;
        hdr_pos_q    <= tlv_ff_pkg::HDR_ID_HI;
        byte_pos_q   <= '0;
        matched_q    <= '0;
        overrun_q    <= 1'b0;
      end else begin
        in_payload_q <= in_payload_d;
        hdr_pos_q    <= hdr_pos_d;
        byte_pos_q   <= byte_pos_d;
        matched_q    <= matched_d;
        overrun_q    <= overrun_d;
      end
    end
  end

endmodule

// ----- rtl/tlv_field_filter.sv -----
// ----------------------------------------------------------------------------
// tlv_field_filter
// Byte-serial type-length-value record parser with an id filter.
// ----------------------------------------------------------------------------
// Bytes of a package enter on in_i, one per transfer, last_byte marking the
// final one. Each record is a 4-byte header (16-bit id, 16-bit size, MSB
// first) followed by its payload. A record is reported on out_o on the byte
// that completes it, if its id equals wanted_id or match_any is set. Every
// package end gives a result too, with incomplete set when a record was cut
// or more than PACKAGE_BYTES bytes arrived. Bytes without a result produce
// no transfer on out_o.
// A byte is first registered in the input register, then parsed while its
// result is registered in the output register that drives out_o.
// Throughput is one byte per cycle unless a result meets a stalled out_o;
// the parser step is combinational header and payload logic.
// When out_o stalls, the finished result waits in the output register while
// the input register still holds one byte; bytes without a result keep
// flowing through the parser. Registers are written on cfg_i (index 0
// wanted_id, index 1 match_any, others ignored) while the block is idle;
// this binds the user, the block does not enforce it. Reset empties both
// registers and returns the parser to the first header byte, match_any set.
// ----------------------------------------------------------------------------
module tlv_field_filter #(
  parameter int unsigned PACKAGE_BYTES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlv_ff_byte_if.sink   in_i,
  tlv_ff_result_if.source out_o,
  tlv_ff_cfg_if.sink    cfg_i
);

  tlv_ff_pkg::cfg_t cfg;
  tlv_ff_pkg::res_t res;
  tlv_ff_pkg::res_t res_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       emit;
  logic       step;

  assign cfg_i.ready = 1'b1;

  tlv_ff_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  tlv_ff_parser #(
    .PACKAGE_BYTES (PACKAGE_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .cfg_i       (cfg),
    .emit_o      (emit),
    .res_o       (res)
  );

  assign step       = in_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.field_found    = res_q.field_found;
  assign out_o.field_id       = res_q.field_id;
  assign out_o.field_size     = res_q.field_size;
  assign out_o.payload_offset = res_q.payload_offset;
  assign out_o.package_end    = res_q.package_end;
  assign out_o.incomplete     = res_q.incomplete;
  assign out_o.fields_matched = res_q.fields_matched;

endmodule

// ----- rtl/tlv_ff_checker.sv -----
// ----------------------------------------------------------------------------
// tlv_ff_checker
// Port-level checks of the TLV field filter, bound to the top level.
// ----------------------------------------------------------------------------
module tlv_ff_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             field_found_i,
  input logic [tlv_ff_pkg::ID_W-1:0]      field_id_i,
  input logic [tlv_ff_pkg::SIZE_W-1:0]    field_size_i,
  input logic [tlv_ff_pkg::OFFSET_W-1:0]  payload_offset_i,
  input logic                             package_end_i,
  input logic                             incomplete_i,
  input logic [tlv_ff_pkg::COUNT_W-1:0]   fields_matched_i
);

  // stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(field_found_i) &&
    $stable(field_id_i) && $stable(package_end_i) && $stable(fields_matched_i))
    else $error("result changed while stalled");

  a_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> field_found_i || package_end_i)
    else $error("result without record or package end");

  a_incomplete_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && incomplete_i |-> package_end_i)
    else $error("incomplete flagged before package end");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !field_found_i |->
    field_id_i == '0 && field_size_i == '0 && payload_offset_i == '0)
    else $error("record fields set without a found record");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && field_found_i |-> fields_matched_i != '0)
    else $error("found record not counted");

endmodule

bind tlv_field_filter tlv_ff_checker u_tlv_ff_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .field_found_i    (out_o.field_found),
  .field_id_i       (out_o.field_id),
  .field_size_i     (out_o.field_size),
  .payload_offset_i (out_o.payload_offset),
  .package_end_i    (out_o.package_end),
  .incomplete_i     (out_o.incomplete),
  .fields_matched_i (out_o.fields_matched)
);
